// ===== rtl/thl_pkg.sv =====
package thl_pkg;

	// default geometry
	localparam int ROWS_PER_HALF_DEF = 4;
	localparam int COLS_DEF          = 8;
	localparam int LAYERS_DEF        = 16;

	// key index width (the 3-bit row and column fields address 8 rows x 8 columns)
	localparam int KEY_MAX_W = 8;

	localparam logic [15:0] HOLD_THR_RST = 16'd20;
	localparam logic [15:0] HOLD_MAX     = 16'hFFFF;

	// command queue between front and back, output buffer (power of two)
	localparam int QDEPTH      = 2;
	localparam int OFIFO_DEPTH = 4;

	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] ACT_PRESS       = 2'd0;
	localparam logic [1:0] ACT_RELEASE     = 2'd1;
	localparam logic [1:0] ACT_RELEASE_ALL = 2'd2;

	typedef struct packed {
		logic        op;
		logic [2:0]  row;
		logic [2:0]  col;
		logic        pressed;
		logic [3:0]  map_layer;
		logic [15:0] map_code;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] key_code;
		logic [3:0]  active_layer;
		logic        last;
	} out_word_t;

	// classified command handed from front to back
	typedef struct packed {
		logic                 op;
		logic                 pressed;
		logic [KEY_MAX_W-1:0] key;
		logic [3:0]           map_layer;
		logic [15:0]          map_code;
	} cmd_t;

endpackage

// ===== rtl/thl_front.sv =====
module thl_front import thl_pkg::*; #(
	parameter int ROWS_PER_HALF = ROWS_PER_HALF_DEF,
	parameter int COLS          = COLS_DEF,
	parameter int LAYERS        = LAYERS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	output logic     q_valid,
	input  logic     q_pop,
	output cmd_t     q_word
);

	localparam int TOTAL_ROWS = 2 * ROWS_PER_HALF;
	localparam int PTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W      = $clog2(QDEPTH + 1);

	cmd_t             q_mem [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_range, lay_ok, keep_word, push;
	cmd_t             cmd;

	assign in_ready = (cnt_q != CNT_W'(QDEPTH));

	// out-of-range positions, and writes to out-of-range layers, are dropped here
	always_comb begin
		in_range = ({2'b00, in_data.row} < 5'(TOTAL_ROWS)) && ({2'b00, in_data.col} < 5'(COLS));
		lay_ok   = ({1'b0, in_data.map_layer} < 5'(LAYERS));
		keep_word = in_range && ((in_data.op == OP_SCAN) || lay_ok);
		cmd.op        = in_data.op;
		cmd.pressed   = in_data.pressed;
		cmd.key       = KEY_MAX_W'(in_data.row) * KEY_MAX_W'(COLS) + KEY_MAX_W'(in_data.col);
		cmd.map_layer = in_data.map_layer;
		cmd.map_code  = in_data.map_code;
	end

	assign push    = in_valid && in_ready && keep_word;
	assign q_valid = (cnt_q != '0);
	assign q_word  = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(q_pop);
		end
	end

endmodule

// ===== rtl/thl_ofifo.sv =====
module thl_ofifo import thl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [1:0] push_n,
	input  out_word_t w0,
	input  out_word_t w1,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int PTR_W = $clog2(OFIFO_DEPTH);
	localparam int CNT_W = $clog2(OFIFO_DEPTH + 1);

	out_word_t        mem [OFIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	// two slots free, enough for any item
	assign room      = (cnt_q <= CNT_W'(OFIFO_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= w0;
		end
		if (push_n == 2'd2) begin
			mem[wr_q + 1'b1] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push_n);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/thl_back.sv =====
module thl_back import thl_pkg::*; #(
	parameter int ROWS_PER_HALF = ROWS_PER_HALF_DEF,
	parameter int COLS          = COLS_DEF,
	parameter int LAYERS        = LAYERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	input  logic        q_valid,
	output logic        q_pop,
	input  cmd_t        q_word,
	input  logic        room,
	output logic [1:0]  push_n,
	output out_word_t   w0,
	output out_word_t   w1
);

	localparam int KEYS      = 2 * ROWS_PER_HALF * COLS;
	localparam int KEY_W     = $clog2(KEYS);
	localparam int MAP_DEPTH = LAYERS * KEYS;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);

	localparam logic ST_ISSUE = 1'b0;
	localparam logic ST_EXEC  = 1'b1;

	logic [15:0]       keymap_mem [MAP_DEPTH];
	logic [15:0]       hold_mem [KEYS];
	logic [KEYS-1:0]   hold_vld_q;

	logic              state_q;
	logic [3:0]        layer_q;
	logic [15:0]       thr_q;

	logic [KEY_W-1:0]  key_s2;
	logic              pressed_s2;
	logic              vld_s2;
	logic [15:0]       hold_rd_s2;
	logic [15:0]       code_s2;

	logic [KEY_W-1:0]  key;
	logic [3:0]        layer_eff, sel_layer;
	logic [MAP_AW-1:0] map_addr;
	logic              map_we, issue_scan, commit;
	logic [15:0]       keep, hold_new;
	logic [3:0]        target, layer_nxt;
	logic              tgt_ok;
	logic [1:0]        n;

	assign key       = q_word.key[KEY_W-1:0];
	assign layer_eff = ({1'b0, layer_q} < 5'(LAYERS)) ? layer_q : 4'd0;
	assign sel_layer = (q_word.op == OP_WRITE) ? q_word.map_layer : layer_eff;
	assign map_addr  = MAP_AW'(sel_layer) * MAP_AW'(KEYS) + MAP_AW'(key);

	assign q_pop      = (state_q == ST_ISSUE) && q_valid;
	assign map_we     = q_pop && (q_word.op == OP_WRITE);
	assign issue_scan = q_pop && (q_word.op == OP_SCAN);
	assign commit     = (state_q == ST_EXEC) && room;

	always_ff @(posedge clk) begin
		if (map_we) begin
			keymap_mem[map_addr] <= q_word.map_code;
		end
		if (issue_scan) begin
			code_s2 <= keymap_mem[map_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hold_mem[key_s2] <= hold_new;
		end
		if (issue_scan) begin
			hold_rd_s2 <= hold_mem[key];
			vld_s2     <= hold_vld_q[key];
			key_s2     <= key;
			pressed_s2 <= q_word.pressed;
		end
	end

	always_comb begin
		keep   = vld_s2 ? hold_rd_s2 : 16'd0;
		target = code_s2[11:8];
		tgt_ok = ({1'b0, target} < 5'(LAYERS));
		if (!pressed_s2) begin
			hold_new = 16'd0;
		end else if (keep == HOLD_MAX) begin
			hold_new = keep;
		end else begin
			hold_new = keep + 16'd1;
		end

		layer_nxt = layer_q;
		n  = 2'd0;
		w0 = '{action: ACT_PRESS, key_code: code_s2, active_layer: 4'd0, last: 1'b0};
		w1 = '{action: ACT_RELEASE, key_code: code_s2, active_layer: 4'd0, last: 1'b1};
		if (pressed_s2) begin
			if (keep == thr_q) begin
				if (target != 4'd0) begin
					if (tgt_ok) begin
						layer_nxt = target;
					end
				end else begin
					n = 2'd1;
				end
			end
		end else if (keep != 16'd0) begin
			if (keep <= thr_q) begin
				n = 2'd2;
			end else if (target != 4'd0) begin
				// long release of a layer key: back to base, drop everything
				layer_nxt   = 4'd0;
				w0.action   = ACT_RELEASE_ALL;
				w0.key_code = 16'd0;
				n = 2'd2;
			end else begin
				w0.action = ACT_RELEASE;
				n = 2'd1;
			end
		end
		w0.active_layer = layer_nxt;
		w1.active_layer = layer_nxt;
		w0.last = (n == 2'd1);
		push_n  = commit ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ISSUE;
			layer_q    <= 4'd0;
			thr_q      <= HOLD_THR_RST;
			hold_vld_q <= '0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			unique case (state_q)
				ST_ISSUE: begin
					if (issue_scan) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q            <= ST_ISSUE;
						layer_q            <= layer_nxt;
						hold_vld_q[key_s2] <= 1'b1;
					end
				end
				default: state_q <= ST_ISSUE;
			endcase
		end
	end

endmodule

// ===== rtl/tap_hold_layer_key_processor_unit.sv =====
// Tap/hold layer key processor. Scan words (op 0) and keymap write words (op 1)
// enter through a two-word command queue, so the input keeps flowing while the
// back end is busy, until the queue fills. A keymap write takes only the issue
// state of the back end; a scan takes issue and exec: issue reads the key's
// hold counter and its keymap entry, exec updates the counter and the layer and
// queues up to two result words. That read-modify-write of the hold-count memory
// sets the scan rate. Results wait in a four-word output buffer; the back end
// holds a finished scan until two slots are free. Hold counters need no clearing
// pass after reset (a valid bit per key stands in for zero). The threshold
// register is always ready and is meant to be written only while the block is idle.
module tap_hold_layer_key_processor_unit import thl_pkg::*; #(
	parameter int ROWS_PER_HALF = ROWS_PER_HALF_DEF,
	parameter int COLS          = COLS_DEF,
	parameter int LAYERS        = LAYERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic      q_valid, q_pop, room;
	cmd_t      q_word;
	logic [1:0] push_n;
	out_word_t w0, w1;

	assign cfg_ready = 1'b1;

	thl_front #(
		.ROWS_PER_HALF(ROWS_PER_HALF),
		.COLS(COLS),
		.LAYERS(LAYERS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_word(q_word)
	);

	thl_back #(
		.ROWS_PER_HALF(ROWS_PER_HALF),
		.COLS(COLS),
		.LAYERS(LAYERS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_word(q_word),
		.room(room),
		.push_n(push_n),
		.w0(w0),
		.w1(w1)
	);

	thl_ofifo u_ofifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.w0(w0),
		.w1(w1),
		.room(room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

// ===== rtl/thl_checker.sv =====
module thl_checker import thl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input out_word_t   out_data
);

	// stalled result word holds
	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result word changed under stall");

	// release-all always carries code 0, base layer, and is never the final word
	property p_relall_form;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_RELEASE_ALL |->
			out_data.key_code == 16'd0 && out_data.active_layer == 4'd0 && !out_data.last;
	endproperty
	a_relall_form: assert property (p_relall_form) else $error("malformed release-all word");

	// both words of an item are buffered together, so the release follows at once
	property p_relall_pair;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.action == ACT_RELEASE_ALL |=>
			out_valid && out_data.action == ACT_RELEASE && out_data.last;
	endproperty
	a_relall_pair: assert property (p_relall_pair) else $error("release-all not followed by release");

	property p_tap_pair;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.action == ACT_PRESS && !out_data.last |=>
			out_valid && out_data.action == ACT_RELEASE && out_data.last &&
			out_data.key_code == $past(out_data.key_code);
	endproperty
	a_tap_pair: assert property (p_tap_pair) else $error("tap press not followed by its release");

endmodule

bind tap_hold_layer_key_processor_unit thl_checker u_thl_checker (.*);
